### sv/lus_pkg.sv
package lus_pkg;

  localparam int unsigned TableEntriesDefault = 16;
  localparam logic signed [15:0] DefaultUnloadPriorityReset = 16'sd0;
  localparam logic [14:0] UnloadThresholdReset = 15'd16;
  localparam logic [7:0] LoadsPerUnloadReset = 8'd4;

  typedef enum logic [1:0] {
    REQ_LOAD     = 2'd0,
    REQ_UNLOAD   = 2'd1,
    REQ_CANCEL   = 2'd2,
    REQ_DISPATCH = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_LOAD_QUEUED       = 4'd0,
    ST_LOAD_SERVED       = 4'd1,
    ST_UNLOAD_QUEUED     = 4'd2,
    ST_CANCELLED         = 4'd3,
    ST_CANCEL_MISS       = 4'd4,
    ST_LOAD_DISPATCHED   = 4'd5,
    ST_UNLOAD_DISPATCHED = 4'd6,
    ST_NOTHING           = 4'd7,
    ST_REJECTED          = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    CFG_PAUSED           = 2'd0,
    CFG_DEFAULT_PRIORITY = 2'd1,
    CFG_THRESHOLD        = 2'd2,
    CFG_LOADS_PER_UNLOAD = 2'd3
  } cfg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [15:0] chunk_x;
    logic signed [15:0] chunk_y;
    logic signed [15:0] load_priority;
    logic [15:0]        buffer_tag;
  } in_t;

  typedef struct packed {
    logic [3:0]         status;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic [15:0]        out_tag;
    logic [4:0]         pending_unloads;
    logic [4:0]         pending_loads;
  } out_t;

  typedef struct packed {
    logic               valid;
    logic               is_unload;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] prio;
    logic [15:0]        tag;
  } entry_t;

endpackage

### sv/lus_cell.sv
module lus_cell
  import lus_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_i,
  input  entry_t next_i,
  input  logic   wr_i,
  input  entry_t wr_data_i,
  output entry_t entry_o
);

  logic   valid_q, valid_d;
  entry_t data_q, data_d;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (wr_i) begin
      valid_d = wr_data_i.valid;
      data_d  = wr_data_i;
    end else if (shift_i) begin
      valid_d = next_i.valid;
      data_d  = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_comb begin
    entry_o       = data_q;
    entry_o.valid = valid_q;
  end

endmodule

### sv/load_unload_request_scheduler.sv
// Pending load/unload request table held in a ring of TABLE_ENTRIES cells that rotates one
// place per cycle, while a request is scanned, past a single inspection point. Each accepted
// request is latched, then the ring is rotated once while the key match, free slot, best load
// and first unload are found, and then the chosen slot is updated and the result presented.
// The output register lets a result wait while the next request is taken. Configuration
// registers are written through cfg_we_i / cfg_idx_i / cfg_data_i.
module load_unload_request_scheduler
  import lus_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  state_e state_q, state_d;
  in_t    req_q;
  logic [IW-1:0] cnt_q, cnt_d;

  logic               paused_q;
  logic signed [15:0] def_prio_q;
  logic [14:0]        thr_q;
  logic [7:0]         lpu_q;
  logic signed [31:0] uprio_q, uprio_d;
  logic [CW-1:0]      lcnt_q, lcnt_d, ucnt_q, ucnt_d;

  logic          m_found_q, f_found_q, bl_found_q, fu_found_q;
  logic [IW-1:0] m_slot_q, f_slot_q, bl_slot_q, fu_slot_q;
  entry_t        m_ent_q, bl_ent_q, fu_ent_q;

  logic   out_valid_q;
  out_t   out_q, out_d;
  logic   apply_go;

  entry_t cells [TABLE_ENTRIES];
  logic   shift;
  logic   wr_en;
  logic [IW-1:0] wr_slot;
  entry_t wr_data;
  entry_t head;

  assign head  = cells[0];
  assign shift = (state_q == S_SCAN);

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_ring
    lus_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (shift),
      .next_i    (cells[(i + 1) % TABLE_ENTRIES]),
      .wr_i      (wr_en && (wr_slot == IW'(i))),
      .wr_data_i (wr_data),
      .entry_o   (cells[i])
    );
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign apply_go    = (state_q == S_APPLY) && (!out_valid_q || !out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_SCAN;
          cnt_d   = '0;
        end
      end
      S_SCAN: begin
        if (cnt_q == IW'(TABLE_ENTRIES - 1)) begin
          state_d = S_APPLY;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_APPLY: begin
        if (apply_go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // apply step
  logic               sel_load;
  logic               do_disp;
  logic signed [32:0] psum;
  logic [CW-1:0]      ucnt_new;

  always_comb begin
    wr_en    = 1'b0;
    wr_slot  = '0;
    wr_data  = '0;
    lcnt_d   = lcnt_q;
    ucnt_d   = ucnt_q;
    uprio_d  = uprio_q;
    out_d    = '0;
    sel_load = 1'b0;
    do_disp  = 1'b0;
    psum     = '0;
    ucnt_new = ucnt_q;
    out_d.status = ST_REJECTED;
    unique case (req_q.req_type)
      REQ_LOAD: begin
        if (m_found_q) begin
          if (m_ent_q.is_unload) begin
            out_d.status  = ST_LOAD_SERVED;
            out_d.out_x   = req_q.chunk_x;
            out_d.out_y   = req_q.chunk_y;
            out_d.out_tag = m_ent_q.tag;
            wr_en   = 1'b1;
            wr_slot = m_slot_q;
            ucnt_d  = ucnt_q - 1'b1;
          end
        end else if (f_found_q) begin
          out_d.status   = ST_LOAD_QUEUED;
          wr_en          = 1'b1;
          wr_slot        = f_slot_q;
          wr_data.valid  = 1'b1;
          wr_data.x      = req_q.chunk_x;
          wr_data.y      = req_q.chunk_y;
          wr_data.prio   = req_q.load_priority;
          lcnt_d         = lcnt_q + 1'b1;
        end
      end
      REQ_UNLOAD: begin
        if (!m_found_q && f_found_q) begin
          out_d.status      = ST_UNLOAD_QUEUED;
          wr_en             = 1'b1;
          wr_slot           = f_slot_q;
          wr_data.valid     = 1'b1;
          wr_data.is_unload = 1'b1;
          wr_data.x         = req_q.chunk_x;
          wr_data.y         = req_q.chunk_y;
          wr_data.tag       = req_q.buffer_tag;
          ucnt_d            = ucnt_q + 1'b1;
        end
      end
      REQ_CANCEL: begin
        if (m_found_q) begin
          out_d.status = ST_CANCELLED;
          wr_en        = 1'b1;
          wr_slot      = m_slot_q;
          if (m_ent_q.is_unload) ucnt_d = ucnt_q - 1'b1;
          else lcnt_d = lcnt_q - 1'b1;
        end else begin
          out_d.status = ST_CANCEL_MISS;
        end
      end
      REQ_DISPATCH: begin
        do_disp = !paused_q && (bl_found_q || fu_found_q);
        if (!fu_found_q) sel_load = 1'b1;
        else if (!bl_found_q) sel_load = 1'b0;
        else sel_load = (32'(bl_ent_q.prio) <= uprio_q);
        if (!do_disp) begin
          out_d.status = ST_NOTHING;
        end else begin
          wr_en = 1'b1;
          if (sel_load) begin
            out_d.status = ST_LOAD_DISPATCHED;
            out_d.out_x  = bl_ent_q.x;
            out_d.out_y  = bl_ent_q.y;
            wr_slot      = bl_slot_q;
            lcnt_d       = lcnt_q - 1'b1;
            psum         = 33'(uprio_q) - 33'sd1;
          end else begin
            out_d.status  = ST_UNLOAD_DISPATCHED;
            out_d.out_x   = fu_ent_q.x;
            out_d.out_y   = fu_ent_q.y;
            out_d.out_tag = fu_ent_q.tag;
            wr_slot       = fu_slot_q;
            ucnt_new      = ucnt_q - 1'b1;
            ucnt_d        = ucnt_new;
            psum          = 33'(uprio_q) + $signed({25'd0, lpu_q});
          end
          if (ucnt_new == '0) begin
            uprio_d = 32'(def_prio_q);
          end else if (32'(ucnt_new) >= 32'(thr_q)) begin
            uprio_d = -$signed({17'd0, thr_q});
          end else if (psum[32] != psum[31]) begin
            uprio_d = psum[32] ? 32'sh80000000 : 32'sh7fffffff;
          end else begin
            uprio_d = psum[31:0];
          end
        end
      end
      default: out_d.status = ST_REJECTED;
    endcase
    out_d.pending_unloads = 5'(ucnt_d);
    out_d.pending_loads   = 5'(lcnt_d);
    if (!apply_go) begin
      wr_en   = 1'b0;
      lcnt_d  = lcnt_q;
      ucnt_d  = ucnt_q;
      uprio_d = uprio_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      lcnt_q      <= '0;
      ucnt_q      <= '0;
      uprio_q     <= 32'(DefaultUnloadPriorityReset);
      paused_q    <= 1'b0;
      def_prio_q  <= DefaultUnloadPriorityReset;
      thr_q       <= UnloadThresholdReset;
      lpu_q       <= LoadsPerUnloadReset;
      m_found_q   <= 1'b0;
      f_found_q   <= 1'b0;
      bl_found_q  <= 1'b0;
      fu_found_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      lcnt_q  <= lcnt_d;
      ucnt_q  <= ucnt_d;
      uprio_q <= uprio_d;
      if (apply_go) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PAUSED:           paused_q   <= cfg_data_i[0];
          CFG_DEFAULT_PRIORITY: def_prio_q <= cfg_data_i;
          CFG_THRESHOLD:        thr_q      <= cfg_data_i[14:0];
          CFG_LOADS_PER_UNLOAD: lpu_q      <= cfg_data_i[7:0];
          default:              paused_q   <= paused_q;
        endcase
      end
      if (state_q == S_IDLE && in_valid_i) begin
        m_found_q  <= 1'b0;
        f_found_q  <= 1'b0;
        bl_found_q <= 1'b0;
        fu_found_q <= 1'b0;
      end else if (state_q == S_SCAN) begin
        if (!m_found_q && head.valid && head.x == req_q.chunk_x
            && head.y == req_q.chunk_y) begin
          m_found_q <= 1'b1;
        end
        if (!f_found_q && !head.valid) f_found_q <= 1'b1;
        if (head.valid && !head.is_unload && (!bl_found_q || head.prio < bl_ent_q.prio)) begin
          bl_found_q <= 1'b1;
        end
        if (!fu_found_q && head.valid && head.is_unload) fu_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) req_q <= in_data_i;
    if (apply_go) out_q <= out_d;
    if (state_q == S_SCAN) begin
      if (!m_found_q && head.valid && head.x == req_q.chunk_x && head.y == req_q.chunk_y) begin
        m_slot_q <= cnt_q;
        m_ent_q  <= head;
      end
      if (!f_found_q && !head.valid) f_slot_q <= cnt_q;
      if (head.valid && !head.is_unload && (!bl_found_q || head.prio < bl_ent_q.prio)) begin
        bl_slot_q <= cnt_q;
        bl_ent_q  <= head;
      end
      if (!fu_found_q && head.valid && head.is_unload) begin
        fu_slot_q <= cnt_q;
        fu_ent_q  <= head;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(lcnt_q) + 32'(ucnt_q)) <= TABLE_ENTRIES)
    else $error("pending count exceeds table size");

  a_ring_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_APPLY |-> cnt_q == '0)
    else $error("ring not back in place at update");

  a_take_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == S_SCAN)
    else $error("transfer did not start a scan");

  a_out_only_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_APPLY)
    else $error("result raised outside update step");

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lus_pkg::*;

  localparam int Slots = 16;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [15:0] cfg_data_i;

  load_unload_request_scheduler dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // scheduler shadow state
  logic sh_paused;
  int sh_default_prio;
  int sh_threshold;
  int sh_loads_per_unload;
  bit slot_used[Slots];
  bit slot_unload[Slots];
  logic [15:0] slot_x[Slots];
  logic [15:0] slot_y[Slots];
  int slot_prio[Slots];
  logic [15:0] slot_tag[Slots];
  int n_loads, n_unloads;
  longint unload_prio;

  in_t pending_reqs[$];
  out_t expected_replies[$];
  int failures = 0;
  bit hold_sender = 0;

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int key_slot(logic [15:0] x, logic [15:0] y);
    for (int i = 0; i < Slots; i++)
      if (slot_used[i] && slot_x[i] == x && slot_y[i] == y) return i;
    return -1;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < Slots; i++) if (!slot_used[i]) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int s);
    slot_used[s] = 0;
    if (slot_unload[s]) begin
      if (n_unloads > 0) n_unloads--;
    end else if (n_loads > 0) n_loads--;
  endfunction

  function automatic out_t schedule(in_t r);
    out_t o;
    int s, bl, fu;
    bit was_unload;
    o = '0;
    o.status = ST_REJECTED;
    case (req_e'(r.req_type))
      REQ_LOAD: begin
        s = key_slot(r.chunk_x, r.chunk_y);
        if (s >= 0) begin
          if (slot_unload[s]) begin
            o.status = ST_LOAD_SERVED;
            o.out_x = r.chunk_x; o.out_y = r.chunk_y; o.out_tag = slot_tag[s];
            drop_slot(s);
          end
        end else begin
          s = free_slot();
          if (s >= 0) begin
            slot_used[s] = 1; slot_unload[s] = 0;
            slot_x[s] = r.chunk_x; slot_y[s] = r.chunk_y;
            slot_prio[s] = int'(r.load_priority); slot_tag[s] = '0;
            n_loads++;
            o.status = ST_LOAD_QUEUED;
          end
        end
      end
      REQ_UNLOAD: begin
        if (key_slot(r.chunk_x, r.chunk_y) < 0) begin
          s = free_slot();
          if (s >= 0) begin
            slot_used[s] = 1; slot_unload[s] = 1;
            slot_x[s] = r.chunk_x; slot_y[s] = r.chunk_y;
            slot_prio[s] = 0; slot_tag[s] = r.buffer_tag;
            n_unloads++;
            o.status = ST_UNLOAD_QUEUED;
          end
        end
      end
      REQ_CANCEL: begin
        s = key_slot(r.chunk_x, r.chunk_y);
        if (s >= 0) begin
          drop_slot(s);
          o.status = ST_CANCELLED;
        end else o.status = ST_CANCEL_MISS;
      end
      default: begin
        s = -1;
        if (!sh_paused) begin
          bl = -1; fu = -1;
          for (int i = 0; i < Slots; i++) begin
            if (slot_used[i] && !slot_unload[i] && (bl < 0 || slot_prio[i] < slot_prio[bl]))
              bl = i;
            if (slot_used[i] && slot_unload[i] && fu < 0) fu = i;
          end
          if (fu < 0) s = bl;
          else if (bl < 0) s = fu;
          else s = (longint'(slot_prio[bl]) <= unload_prio) ? bl : fu;
        end
        if (s < 0) o.status = ST_NOTHING;
        else begin
          was_unload = slot_unload[s];
          o.out_x = slot_x[s]; o.out_y = slot_y[s];
          if (was_unload) o.out_tag = slot_tag[s];
          o.status = was_unload ? ST_UNLOAD_DISPATCHED : ST_LOAD_DISPATCHED;
          drop_slot(s);
          if (n_unloads == 0) unload_prio = sh_default_prio;
          else if (n_unloads >= sh_threshold) unload_prio = -sh_threshold;
          else begin
            unload_prio = unload_prio + (was_unload ? sh_loads_per_unload : -1);
            if (unload_prio > 64'sd2147483647) unload_prio = 64'sd2147483647;
            if (unload_prio < -64'sd2147483648) unload_prio = -64'sd2147483648;
          end
        end
      end
    endcase
    o.pending_unloads = n_unloads[4:0];
    o.pending_loads = n_loads[4:0];
    return o;
  endfunction

  // driver: bursts with gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
    end else if (in_valid_i && !in_stall_o) begin
      expected_replies.insert(expected_replies.size(), schedule(in_data_i));
      void'(pending_reqs.pop_front());
      if (burst_left > 0) burst_left--;
      if (pending_reqs.size() > 0 && !hold_sender && burst_left > 0) begin
        in_data_i <= pending_reqs[0];
      end else begin
        in_valid_i <= 0;
        gap_left <= (burst_left == 0) ? $urandom_range(0, 40) : 0;
      end
    end else if (!in_valid_i) begin
      if (gap_left > 0) gap_left <= gap_left - 1;
      else if (pending_reqs.size() > 0 && !hold_sender) begin
        in_valid_i <= 1;
        in_data_i <= pending_reqs[0];
        if (burst_left == 0) burst_left = ($urandom_range(0, 3) == 0) ? 1000 : $urandom_range(1, 8);
      end
    end
  end

  // monitor
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_replies.size() == 0) begin
          $error("transfer with no expected result");
          failures++;
        end else begin
          out_t e;
          e = expected_replies.pop_front();
          if (out_data_o.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_data_o.status); failures++;
          end
          if (out_data_o.out_x !== e.out_x) begin
            $error("out_x expected %0d actual %0d", e.out_x, out_data_o.out_x); failures++;
          end
          if (out_data_o.out_y !== e.out_y) begin
            $error("out_y expected %0d actual %0d", e.out_y, out_data_o.out_y); failures++;
          end
          if (out_data_o.out_tag !== e.out_tag) begin
            $error("out_tag expected %0d actual %0d", e.out_tag, out_data_o.out_tag); failures++;
          end
          if (out_data_o.pending_unloads !== e.pending_unloads) begin
            $error("pending_unloads expected %0d actual %0d", e.pending_unloads,
                   out_data_o.pending_unloads); failures++;
          end
          if (out_data_o.pending_loads !== e.pending_loads) begin
            $error("pending_loads expected %0d actual %0d", e.pending_loads,
                   out_data_o.pending_loads); failures++;
          end
        end
      end
      if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall_i <= 0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  function automatic in_t make_req(req_e t, logic [15:0] x, logic [15:0] y,
                                   logic [15:0] p, logic [15:0] tag);
    in_t r;
    r.req_type = t; r.chunk_x = x; r.chunk_y = y; r.load_priority = p; r.buffer_tag = tag;
    return r;
  endfunction

  function automatic void add_req(in_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_replies.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    case (idx)
      CFG_PAUSED: sh_paused = val[0];
      CFG_DEFAULT_PRIORITY: sh_default_prio = int'($signed(val));
      CFG_THRESHOLD: sh_threshold = int'(val[14:0]);
      default: sh_loads_per_unload = int'(val[7:0]);
    endcase
  endtask

  // keys from a small pool so hits are common; sometimes the full range
  function automatic logic [15:0] pick_coord();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 5)) ^ {16{$urandom_range(0, 1) == 1}};
  endfunction

  function automatic in_t random_req();
    int k;
    logic [15:0] p;
    k = $urandom_range(0, 99);
    p = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($signed($urandom_range(0, 40)) - 20);
    if (k < 32) return make_req(REQ_LOAD, pick_coord(), pick_coord(), p, 16'($urandom));
    if (k < 58) return make_req(REQ_UNLOAD, pick_coord(), pick_coord(), p, 16'($urandom));
    if (k < 70) return make_req(REQ_CANCEL, pick_coord(), pick_coord(), p, 16'($urandom));
    return make_req(REQ_DISPATCH, pick_coord(), pick_coord(), p, 16'($urandom));
  endfunction

  initial begin
    rst_ni = 0; in_valid_i = 0; in_data_i = '0; out_stall_i = 0;
    cfg_we_i = 0; cfg_idx_i = CFG_PAUSED; cfg_data_i = '0;
    sh_paused = 0; sh_default_prio = 0; sh_threshold = 16; sh_loads_per_unload = 4;
    n_loads = 0; n_unloads = 0; unload_prio = 0;
    foreach (slot_used[i]) slot_used[i] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    repeat (2) @(posedge clk_i);

    // directed
    add_req(make_req(REQ_DISPATCH, 0, 0, 0, 0));
    add_req(make_req(REQ_LOAD, 16'h8000, 16'h7fff, 16'h7fff, 16'hffff));
    add_req(make_req(REQ_LOAD, 16'h8000, 16'h7fff, 16'h0000, 0));
    add_req(make_req(REQ_LOAD, 16'h7fff, 16'h8000, 16'h8000, 0));
    add_req(make_req(REQ_LOAD, 1, 1, 16'h8000, 0));
    add_req(make_req(REQ_UNLOAD, 16'h7fff, 16'h8000, 0, 16'hffff));
    add_req(make_req(REQ_UNLOAD, 16'hffff, 16'hffff, 0, 16'hffff));
    add_req(make_req(REQ_LOAD, 16'hffff, 16'hffff, 5, 0));
    add_req(make_req(REQ_UNLOAD, 2, 2, 0, 16'h1234));
    add_req(make_req(REQ_CANCEL, 2, 2, 0, 0));
    add_req(make_req(REQ_CANCEL, 2, 2, 0, 0));
    add_req(make_req(REQ_UNLOAD, 3, 3, 0, 16'h00aa));
    add_req(make_req(REQ_DISPATCH, 0, 0, 0, 0));
    add_req(make_req(REQ_DISPATCH, 0, 0, 0, 0));
    add_req(make_req(REQ_DISPATCH, 0, 0, 0, 0));
    add_req(make_req(REQ_DISPATCH, 0, 0, 0, 0));
    add_req(make_req(REQ_DISPATCH, 0, 0, 0, 0));
    for (int i = 0; i < 17; i++)
      add_req(make_req(i % 2 ? REQ_UNLOAD : REQ_LOAD, 16'(i + 100), 7,
                       16'(i), 16'(i)));
    wait_drained();

    // paused: dispatch reports nothing, unload still taken
    write_reg(CFG_PAUSED, 16'h0001);
    add_req(make_req(REQ_DISPATCH, 0, 0, 0, 0));
    for (int i = 0; i < 17; i++)
      add_req(make_req(REQ_CANCEL, 16'(i + 100), 7, 0, 0));
    add_req(make_req(REQ_UNLOAD, 9, 9, 0, 16'h5555));
    add_req(make_req(REQ_DISPATCH, 0, 0, 0, 0));
    wait_drained();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_PAUSED, 0); write_reg(CFG_DEFAULT_PRIORITY, 16'h7fff);
          write_reg(CFG_THRESHOLD, 16'h7fff); write_reg(CFG_LOADS_PER_UNLOAD, 16'h00ff);
        end
        1: begin
          write_reg(CFG_DEFAULT_PRIORITY, 16'h8000);
          write_reg(CFG_THRESHOLD, 1); write_reg(CFG_LOADS_PER_UNLOAD, 1);
        end
        2: begin
          write_reg(CFG_DEFAULT_PRIORITY, 0);
          write_reg(CFG_THRESHOLD, 16'h0000); write_reg(CFG_LOADS_PER_UNLOAD, 16'hff00);
        end
        3: write_reg(CFG_PAUSED, 16'hfffe);
        4: begin
          write_reg(CFG_THRESHOLD, 16'hffff); write_reg(CFG_LOADS_PER_UNLOAD, 16'h0080);
          write_reg(CFG_DEFAULT_PRIORITY, 16'hfff0);
        end
        5: write_reg(CFG_PAUSED, 1);
        default: begin
          write_reg(CFG_PAUSED, 0); write_reg(CFG_THRESHOLD, 16'($urandom_range(1, 8)));
          write_reg(CFG_LOADS_PER_UNLOAD, 16'($urandom_range(1, 20)));
          write_reg(CFG_DEFAULT_PRIORITY, 16'($urandom));
        end
      endcase
      for (int i = 0; i < ((ph == 5) ? 50 : 275); i++) add_req(random_req());
      if (ph == 2) begin
        // sender holds until every outstanding result is back
        repeat (300) @(posedge clk_i);
        hold_sender = 1;
        @(posedge clk_i);
        while (in_valid_i || expected_replies.size() > 0) @(posedge clk_i);
        hold_sender = 0;
      end
      wait_drained();
    end
    repeat (60) @(posedge clk_i);
    if (failures == 0 && expected_replies.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
